@@ hw/rtl/dta_pkg.sv @@
// Shared types, command codes and constants for the duration arithmetic unit.
package dta_pkg;

  // Command codes
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_INC = 3'd3;
  localparam logic [2:0] CMD_DEC = 3'd4;

  // Time constants
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_DAY  = 86400;
  localparam logic [4:0]  MAX_HOUR     = 5'd23;
  localparam logic [5:0]  MAX_MIN_SEC  = 6'd59;

  // Internal widths
  localparam int T_W = 33;   // seconds part, offset so it never goes negative
  localparam int D_W = 34;   // signed day count
  localparam int Q_W = 17;   // whole days taken out of the seconds part
  localparam int R_W = 17;   // seconds of day, below 86400

  // Reciprocals for constant division: x / d == (x * RCP) >> SH over the used range.
  // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15.
  localparam logic [26:0] RCP_675    = 27'd101806633;
  localparam int          RCP_675_SH = 36;
  localparam logic [13:0] RCP_225    = 14'd9321;
  localparam int          RCP_225_SH = 21;
  localparam logic [15:0] RCP_15     = 16'd34953;
  localparam int          RCP_15_SH  = 19;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] a_days;
    logic [4:0]  a_hours;
    logic [5:0]  a_minutes;
    logic [5:0]  a_seconds;
    logic [15:0] b_days;
    logic [4:0]  b_hours;
    logic [5:0]  b_minutes;
    logic [5:0]  b_seconds;
    logic [15:0] factor;
  } dta_in_t;

  typedef struct packed {
    logic [15:0] r_days;
    logic [4:0]  r_hours;
    logic [5:0]  r_minutes;
    logic [5:0]  r_seconds;
    logic        underflow;
    logic        overflow;
    logic        a_less;
    logic        a_equal;
    logic        a_greater;
  } dta_out_t;

  typedef struct packed {
    logic less;
    logic equal;
    logic greater;
  } dta_cmp_t;

  // After operand prep: days and seconds not yet normalized
  typedef struct packed {
    logic [T_W-1:0]        secs;
    logic signed [D_W-1:0] days;
    dta_cmp_t              cmp;
  } dta_sum_t;

  // After the day quotient estimate
  typedef struct packed {
    logic [Q_W-1:0]        q;
    logic [T_W-1:0]        secs;
    logic signed [D_W-1:0] days;
    dta_cmp_t              cmp;
  } dta_quo_t;

  // Day count settled, seconds of day left
  typedef struct packed {
    logic [R_W-1:0] rem;
    logic [15:0]    days;
    logic           neg;
    logic           sat;
    dta_cmp_t       cmp;
  } dta_rem_t;

  // Hours and total minutes of day known
  typedef struct packed {
    logic [4:0]     hours;
    logic [10:0]    mins_total;
    logic [R_W-1:0] rem;
    logic [15:0]    days;
    logic           neg;
    logic           sat;
    dta_cmp_t       cmp;
  } dta_hms_t;

  // Load enables of a module holding two pipeline stages
  typedef struct packed {
    logic first;
    logic second;
  } dta_stage_en_t;

  function automatic logic [16:0] secs_of(input logic [4:0] h, input logic [5:0] m,
                                          input logic [5:0] s);
    return 17'(h) * 17'(SEC_PER_HOUR) + 17'(m) * 17'(SEC_PER_MIN) + 17'(s);
  endfunction

endpackage

@@ hw/rtl/dta_front.sv @@
// Operand prep stage: seconds of each operand, command select, multiply, compare.
module dta_front
  import dta_pkg::*;
#(
  parameter int DAY_BITS = 16
) (
  input  logic     clk,
  input  logic     en,
  input  dta_in_t  item,
  output dta_sum_t sum
);

  localparam int          USE_BITS = (DAY_BITS < 16) ? DAY_BITS : 16;
  localparam logic [15:0] DAY_MASK = 16'(16'hFFFF >> (16 - USE_BITS));

  logic [15:0] ad;
  logic [15:0] bd;
  logic [16:0] ra;
  logic [16:0] rb;
  logic [T_W-1:0] mul_secs;
  logic [31:0] mul_days;
  dta_sum_t sum_next;

  assign ad = item.a_days & DAY_MASK;
  assign bd = item.b_days & DAY_MASK;
  assign ra = secs_of(item.a_hours, item.a_minutes, item.a_seconds);
  assign rb = secs_of(item.b_hours, item.b_minutes, item.b_seconds);

  assign mul_secs = T_W'(ra) * T_W'(item.factor);
  assign mul_days = 32'(ad) * 32'(item.factor);

  // Negative seconds parts get whole days added so the divider sees a non-negative value
  always_comb begin
    unique case (item.cmd)
      CMD_ADD: begin
        sum_next.secs = T_W'(ra) + T_W'(rb);
        sum_next.days = D_W'(ad) + D_W'(bd);
      end
      CMD_SUB: begin
        sum_next.secs = T_W'(ra) + T_W'(2 * SEC_PER_DAY) - T_W'(rb);
        sum_next.days = D_W'(ad) - D_W'(bd) - D_W'(2);
      end
      CMD_MUL: begin
        sum_next.secs = mul_secs;
        sum_next.days = D_W'(mul_days);
      end
      CMD_INC: begin
        sum_next.secs = T_W'(ra) + T_W'(1);
        sum_next.days = D_W'(ad);
      end
      CMD_DEC: begin
        sum_next.secs = T_W'(ra) + T_W'(SEC_PER_DAY) - T_W'(1);
        sum_next.days = D_W'(ad) - D_W'(1);
      end
      default: begin
        sum_next.secs = T_W'(ra);
        sum_next.days = D_W'(ad);
      end
    endcase

    // Lexicographic compare on raw fields
    if (ad != bd) begin
      sum_next.cmp.less = (ad < bd);
    end else if (item.a_hours != item.b_hours) begin
      sum_next.cmp.less = (item.a_hours < item.b_hours);
    end else if (item.a_minutes != item.b_minutes) begin
      sum_next.cmp.less = (item.a_minutes < item.b_minutes);
    end else begin
      sum_next.cmp.less = (item.a_seconds < item.b_seconds);
    end
    sum_next.cmp.equal = (ad == bd) && (item.a_hours == item.b_hours) &&
                         (item.a_minutes == item.b_minutes) &&
                         (item.a_seconds == item.b_seconds);
    sum_next.cmp.greater = !sum_next.cmp.less && !sum_next.cmp.equal;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sum_next;
    end
  end

endmodule

@@ hw/rtl/dta_days.sv @@
// Day split: whole days out of the seconds part, day total and range flags.
module dta_days
  import dta_pkg::*;
#(
  parameter int DAY_BITS = 16
) (
  input  logic          clk,
  input  dta_stage_en_t en,
  input  dta_sum_t      sum,
  output dta_rem_t      rem
);

  localparam int N_W = T_W - 7;
  localparam int P_W = N_W + 27;
  localparam logic signed [D_W-1:0] DAY_MAX = D_W'((64'd1 << DAY_BITS) - 64'd1);

  logic [P_W-1:0] q_prod;
  dta_quo_t quo_next;
  dta_quo_t quo;
  logic [T_W-1:0] full_rem;
  logic signed [D_W-1:0] days_sum;
  dta_rem_t rem_next;

  // secs / 86400 == (secs >> 7) / 675
  assign q_prod = P_W'(sum.secs[T_W-1:7]) * P_W'(RCP_675);

  always_comb begin
    quo_next.q    = q_prod[RCP_675_SH +: Q_W];
    quo_next.secs = sum.secs;
    quo_next.days = sum.days;
    quo_next.cmp  = sum.cmp;
  end

  always_ff @(posedge clk) begin
    if (en.first) begin
      quo <= quo_next;
    end
  end

  assign full_rem = quo.secs - T_W'(quo.q) * T_W'(SEC_PER_DAY);
  assign days_sum = quo.days + $signed(D_W'(quo.q));

  always_comb begin
    rem_next.rem  = full_rem[R_W-1:0];
    rem_next.days = days_sum[15:0];
    rem_next.neg  = (days_sum < 0);
    rem_next.sat  = (days_sum >= 0) && (days_sum > DAY_MAX);
    rem_next.cmp  = quo.cmp;
  end

  always_ff @(posedge clk) begin
    if (en.second) begin
      rem <= rem_next;
    end
  end

endmodule

@@ hw/rtl/dta_clock.sv @@
// Clock split: hours, minutes, seconds of day, then zeroing or saturation.
module dta_clock
  import dta_pkg::*;
#(
  parameter int DAY_BITS = 16
) (
  input  logic          clk,
  input  dta_stage_en_t en,
  input  dta_rem_t      rem,
  output dta_out_t      res
);

  localparam logic [15:0] SAT_DAYS = 16'((64'd1 << DAY_BITS) - 64'd1);

  logic [26:0] h_prod;
  logic [30:0] m_prod;
  dta_hms_t hms_next;
  dta_hms_t hms;
  logic [10:0] mins;
  logic [R_W-1:0] secs;
  dta_out_t res_next;

  // rem / 3600 == (rem >> 4) / 225, rem / 60 == (rem >> 2) / 15
  assign h_prod = 27'(rem.rem[R_W-1:4]) * 27'(RCP_225);
  assign m_prod = 31'(rem.rem[R_W-1:2]) * 31'(RCP_15);

  always_comb begin
    hms_next.hours      = h_prod[RCP_225_SH +: 5];
    hms_next.mins_total = m_prod[RCP_15_SH +: 11];
    hms_next.rem        = rem.rem;
    hms_next.days       = rem.days;
    hms_next.neg        = rem.neg;
    hms_next.sat        = rem.sat;
    hms_next.cmp        = rem.cmp;
  end

  always_ff @(posedge clk) begin
    if (en.first) begin
      hms <= hms_next;
    end
  end

  assign mins = hms.mins_total - 11'(hms.hours) * 11'(SEC_PER_MIN);
  assign secs = hms.rem - R_W'(hms.mins_total) * R_W'(SEC_PER_MIN);

  always_comb begin
    res_next.a_less    = hms.cmp.less;
    res_next.a_equal   = hms.cmp.equal;
    res_next.a_greater = hms.cmp.greater;
    res_next.underflow = hms.neg;
    res_next.overflow  = hms.sat;
    if (hms.neg) begin
      res_next.r_days    = '0;
      res_next.r_hours   = '0;
      res_next.r_minutes = '0;
      res_next.r_seconds = '0;
    end else if (hms.sat) begin
      res_next.r_days    = SAT_DAYS;
      res_next.r_hours   = MAX_HOUR;
      res_next.r_minutes = MAX_MIN_SEC;
      res_next.r_seconds = MAX_MIN_SEC;
    end else begin
      res_next.r_days    = hms.days;
      res_next.r_hours   = hms.hours;
      res_next.r_minutes = mins[5:0];
      res_next.r_seconds = secs[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.second) begin
      res <= res_next;
    end
  end

endmodule

@@ hw/rtl/duration_time_alu.sv @@
// Top level of the duration arithmetic unit: handshake, pipeline control, stages.
//
// Arithmetic on durations given as days, hours, minutes and seconds: add, subtract,
// scale a by factor, step a up or down by one second; results normalized at 60/60/24,
// negative results zeroed with underflow, day counts above 2^DAY_BITS-1 saturated to
// that many days at 23:59:59 with overflow, plus the raw-field compare of a against b.
// The unit is a six-stage pipeline (input register, operand prep and multiply, day
// quotient, day total, hour/minute quotients, final fields) and takes one item every
// cycle unless a full pipe is held by res_stall. Each stage moves as soon as the one
// after it is free, so empty slots are filled even while res is stalled.
// The stage count is set by the constant divisions by 86400, 3600 and 60, each done
// as a registered reciprocal multiply. Operand days use their low DAY_BITS bits.
module duration_time_alu
  import dta_pkg::*;
#(
  parameter int DAY_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     op_valid,
  output logic     op_stall,
  input  dta_in_t  op,
  output logic     res_valid,
  input  logic     res_stall,
  output dta_out_t res
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;
  dta_in_t  op_q;
  dta_sum_t sum;
  dta_rem_t rem;
  dta_stage_en_t days_en;
  dta_stage_en_t clock_en;

  // A stage may load when it is empty or its item moves on this cycle
  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || !res_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= op_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      op_q <= op;
    end
  end

  assign days_en.first   = adv[2];
  assign days_en.second  = adv[3];
  assign clock_en.first  = adv[4];
  assign clock_en.second = adv[5];

  dta_front #(.DAY_BITS(DAY_BITS)) u_front (
    .clk  (clk),
    .en   (adv[1]),
    .item (op_q),
    .sum  (sum)
  );

  dta_days #(.DAY_BITS(DAY_BITS)) u_days (
    .clk (clk),
    .en  (days_en),
    .sum (sum),
    .rem (rem)
  );

  dta_clock #(.DAY_BITS(DAY_BITS)) u_clock (
    .clk (clk),
    .en  (clock_en),
    .rem (rem),
    .res (res)
  );

  assign op_stall  = !adv[0];
  assign res_valid = vld[NSTG-1];

  // An accepted item always lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    op_valid && !op_stall |=> vld[0])
    else $error("accepted item not captured");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $onehot({res.a_less, res.a_equal, res.a_greater}))
    else $error("compare flags not one-hot");

  a_underflow_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.underflow |-> !res.overflow && res.r_days == '0 &&
      res.r_hours == '0 && res.r_minutes == '0 && res.r_seconds == '0)
    else $error("underflow result not zeroed");

  a_fields_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.r_hours <= MAX_HOUR && res.r_minutes <= MAX_MIN_SEC &&
      res.r_seconds <= MAX_MIN_SEC)
    else $error("result fields not normalized");

endmodule

@@ tb/sv/tb_duration_time_alu.sv @@
// Self-checking testbench for duration_time_alu: directed and random items against a predictor.
`timescale 1ns / 100ps

module tb_duration_time_alu
  import dta_pkg::*;
();

  // Only the default day width is tested. The predictor keeps its own constants in
  // signed 64-bit terms, so negative second counts divide with a floor correction.
  localparam int     DAY_BITS     = 16;
  localparam longint DAY_LIMIT    = (longint'(1) << DAY_BITS) - 1;
  localparam longint DAY_SECS     = 86400;
  localparam longint HOUR_SECS    = 3600;
  localparam longint MIN_SECS     = 60;
  localparam int     HOLD_CYCLES  = 60;     // long output hold-off, far beyond pipe depth
  localparam int     DRAIN_CYCLES = 20;     // pipeline is six deep; wait a bit past that
  localparam longint TIMEOUT_NS   = 2000000;

  logic     clk;
  logic     rst       = 1'b1;
  logic     op_valid  = 1'b0;
  logic     op_stall;
  dta_in_t  op        = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  dta_out_t res;

  // Output hold-off request, driven only by the hold-off process.
  logic     hold_res  = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;

  // Results owed by the unit, oldest first.
  dta_out_t pending_results[$];

  duration_time_alu #(
    .DAY_BITS(DAY_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_stall (op_stall),
    .op       (op),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Global watchdog, set far beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: time parts go to seconds, days stay apart, the result is computed
  // exactly, then split back into days and time of day. Division truncates toward
  // zero, so a negative remainder is folded back into the previous day.
  // ---------------------------------------------------------------------------
  function automatic dta_out_t predict_duration(dta_in_t x);
    longint   ad, bd, sa, sb, fac, days, secs, q, r, prod;
    logic [32:0] a_key, b_key;
    dta_out_t y;
    ad  = longint'(x.a_days) & DAY_LIMIT;
    bd  = longint'(x.b_days) & DAY_LIMIT;
    sa  = longint'(x.a_hours) * HOUR_SECS + longint'(x.a_minutes) * MIN_SECS
          + longint'(x.a_seconds);
    sb  = longint'(x.b_hours) * HOUR_SECS + longint'(x.b_minutes) * MIN_SECS
          + longint'(x.b_seconds);
    fac = longint'(x.factor);
    case (x.cmd)
      CMD_ADD: begin
        days = ad + bd;
        secs = sa + sb;
      end
      CMD_SUB: begin
        days = ad - bd;
        secs = sa - sb;
      end
      CMD_MUL: begin
        prod = sa * fac;
        days = ad * fac + prod / DAY_SECS;
        secs = prod % DAY_SECS;
      end
      CMD_INC: begin
        days = ad;
        secs = sa + 1;
      end
      CMD_DEC: begin
        days = ad;
        secs = sa - 1;
      end
      default: begin
        // spare codes pass a through, normalized
        days = ad;
        secs = sa;
      end
    endcase

    q = secs / DAY_SECS;
    r = secs % DAY_SECS;
    if (r < 0) begin
      r += DAY_SECS;
      q -= 1;
    end
    days += q;

    y = '0;
    if (days < 0) begin
      y.underflow = 1'b1;
    end else if (days > DAY_LIMIT) begin
      // saturate to the longest representable duration
      y.r_days    = 16'(DAY_LIMIT);
      y.r_hours   = MAX_HOUR;
      y.r_minutes = MAX_MIN_SEC;
      y.r_seconds = MAX_MIN_SEC;
      y.overflow  = 1'b1;
    end else begin
      y.r_days    = 16'(days);
      y.r_hours   = 5'(r / HOUR_SECS);
      y.r_minutes = 6'((r / MIN_SECS) % 60);
      y.r_seconds = 6'(r % 60);
    end

    // Raw-field compare; fixed-width concatenation orders the same as field by field.
    a_key = {16'(ad), x.a_hours, x.a_minutes, x.a_seconds};
    b_key = {16'(bd), x.b_hours, x.b_minutes, x.b_seconds};
    y.a_less    = a_key < b_key;
    y.a_equal   = a_key == b_key;
    y.a_greater = a_key > b_key;
    return y;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: record the expected result of every item the unit takes.
  // Signals are read right after the edge, i.e. their values before the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && op_valid && !op_stall)
      pending_results.push_back(predict_duration(op));
  end

  // Receiver: random stall at the current rate, or held high during a hold-off.
  always @(posedge clk) begin
    res_stall <= hold_res || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Output side: compare each result taken with the oldest expectation.
  always @(posedge clk) begin
    dta_out_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: no item pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("r_days",    longint'(want.r_days),    longint'(res.r_days));
        check_field("r_hours",   longint'(want.r_hours),   longint'(res.r_hours));
        check_field("r_minutes", longint'(want.r_minutes), longint'(res.r_minutes));
        check_field("r_seconds", longint'(want.r_seconds), longint'(res.r_seconds));
        check_field("underflow", longint'(want.underflow), longint'(res.underflow));
        check_field("overflow",  longint'(want.overflow),  longint'(res.overflow));
        check_field("a_less",    longint'(want.a_less),    longint'(res.a_less));
        check_field("a_equal",   longint'(want.a_equal),   longint'(res.a_equal));
        check_field("a_greater", longint'(want.a_greater), longint'(res.a_greater));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: optional random idle cycles, then offer the item and hold it until
  // taken. op_valid stays high on return so back-to-back items need no toggle.
  // ---------------------------------------------------------------------------
  task automatic send_item(dta_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    op_valid <= 1'b1;
    op       <= item;
    do @(posedge clk); while (op_stall);
  endtask

  function automatic dta_in_t make_item(logic [2:0] c,
                                        logic [15:0] ad, logic [4:0] ah,
                                        logic [5:0] am, logic [5:0] as_,
                                        logic [15:0] bd, logic [4:0] bh,
                                        logic [5:0] bm, logic [5:0] bs,
                                        logic [15:0] fac);
    dta_in_t x;
    x.cmd       = c;
    x.a_days    = ad;
    x.a_hours   = ah;
    x.a_minutes = am;
    x.a_seconds = as_;
    x.b_days    = bd;
    x.b_hours   = bh;
    x.b_minutes = bm;
    x.b_seconds = bs;
    x.factor    = fac;
    return x;
  endfunction

  // Day counts lean on the ends so carries into and out of the day range are common.
  function automatic logic [15:0] rand_days();
    case ($urandom_range(3))
      0:       return 16'($urandom_range(3));
      1:       return 16'hFFFF - 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly normalized operands; a minority uses the full raw field widths.
  function automatic dta_in_t rand_duration_item();
    dta_in_t x;
    x = '0;
    x.cmd    = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    x.a_days = rand_days();
    x.b_days = rand_days();
    if ($urandom_range(99) < 85) begin
      x.a_hours   = 5'($urandom_range(23));
      x.a_minutes = 6'($urandom_range(59));
      x.a_seconds = 6'($urandom_range(59));
      x.b_hours   = 5'($urandom_range(23));
      x.b_minutes = 6'($urandom_range(59));
      x.b_seconds = 6'($urandom_range(59));
    end else begin
      x.a_hours   = 5'($urandom);
      x.a_minutes = 6'($urandom);
      x.a_seconds = 6'($urandom);
      x.b_hours   = 5'($urandom);
      x.b_minutes = 6'($urandom);
      x.b_seconds = 6'($urandom);
    end
    // steer the compare: equal operands, or equal down to the seconds
    case ($urandom_range(9))
      0: {x.b_days, x.b_hours, x.b_minutes, x.b_seconds} =
           {x.a_days, x.a_hours, x.a_minutes, x.a_seconds};
      1: begin
        {x.b_days, x.b_hours, x.b_minutes} = {x.a_days, x.a_hours, x.a_minutes};
        x.b_seconds = 6'($urandom_range(59));
      end
      default: ;
    endcase
    case ($urandom_range(3))
      0:       x.factor = 16'($urandom_range(1));
      1:       x.factor = 16'($urandom_range(16));
      2:       x.factor = 16'($urandom_range(2000));
      default: x.factor = 16'($urandom);
    endcase
    // small days keep products in range often enough to see real fields
    if (x.cmd == CMD_MUL && $urandom_range(1))
      x.a_days = 16'($urandom_range(40));
    return x;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every command, and the corner behaviors of the unit.
  task automatic test_directed_cases();
    // add: zero, carry through hours into days, day saturation
    send_item(make_item(CMD_ADD, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0));
    send_item(make_item(CMD_ADD, 16'd0, 5'd23, 6'd59, 6'd59,
                        16'd0, 5'd0, 6'd0, 6'd1, 16'd0));
    send_item(make_item(CMD_ADD, 16'hFFFF, 5'd23, 6'd59, 6'd59,
                        16'd0, 5'd0, 6'd0, 6'd1, 16'hFFFF));
    send_item(make_item(CMD_ADD, 16'hFFFF, 5'd23, 6'd59, 6'd59,
                        16'hFFFF, 5'd23, 6'd59, 6'd59, 16'd0));
    // subtract: equal operands, borrow across a day, negative results
    send_item(make_item(CMD_SUB, 16'd5, 5'd10, 6'd20, 6'd30,
                        16'd5, 5'd10, 6'd20, 6'd30, 16'd0));
    send_item(make_item(CMD_SUB, 16'd1, 5'd0, 6'd0, 6'd0, 16'd0, 5'd0, 6'd0, 6'd1, 16'd0));
    send_item(make_item(CMD_SUB, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0, 5'd0, 6'd0, 6'd1, 16'd0));
    send_item(make_item(CMD_SUB, 16'd0, 5'd0, 6'd0, 6'd0,
                        16'hFFFF, 5'd23, 6'd59, 6'd59, 16'd0));
    send_item(make_item(CMD_SUB, 16'd3, 5'd1, 6'd0, 6'd0, 16'd2, 5'd2, 6'd0, 6'd0, 16'd0));
    // multiply: by zero, by one, by the largest factor, half a day doubled
    send_item(make_item(CMD_MUL, 16'hFFFF, 5'd23, 6'd59, 6'd59,
                        16'd0, 5'd0, 6'd0, 6'd0, 16'd0));
    send_item(make_item(CMD_MUL, 16'd1234, 5'd7, 6'd8, 6'd9,
                        16'd0, 5'd0, 6'd0, 6'd0, 16'd1));
    send_item(make_item(CMD_MUL, 16'd0, 5'd0, 6'd0, 6'd1,
                        16'd0, 5'd0, 6'd0, 6'd0, 16'hFFFF));
    send_item(make_item(CMD_MUL, 16'd0, 5'd12, 6'd0, 6'd0, 16'd0, 5'd0, 6'd0, 6'd0, 16'd2));
    // increment / decrement across day boundaries and range ends
    send_item(make_item(CMD_INC, 16'd0, 5'd23, 6'd59, 6'd59,
                        16'd0, 5'd0, 6'd0, 6'd0, 16'd0));
    send_item(make_item(CMD_INC, 16'hFFFF, 5'd23, 6'd59, 6'd59,
                        16'd0, 5'd0, 6'd0, 6'd0, 16'd0));
    send_item(make_item(CMD_DEC, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0));
    send_item(make_item(CMD_DEC, 16'd1, 5'd0, 6'd0, 6'd0, 16'd0, 5'd0, 6'd0, 6'd0, 16'd0));
    // raw fields beyond their normal range are carried, compare stays raw
    send_item(make_item(CMD_ADD, 16'd0, 5'd31, 6'd63, 6'd63,
                        16'd0, 5'd31, 6'd63, 6'd63, 16'd0));
    send_item(make_item(CMD_INC, 16'd0, 5'd31, 6'd63, 6'd63,
                        16'd1, 5'd0, 6'd0, 6'd0, 16'd0));
    send_item(make_item(CMD_SUB, 16'd0, 5'd24, 6'd0, 6'd0, 16'd1, 5'd0, 6'd0, 6'd0, 16'd0));
    // spare command codes pass a through, including a saturating one
    send_item(make_item(3'd5, 16'd3, 5'd4, 6'd5, 6'd6, 16'd9, 5'd0, 6'd0, 6'd0, 16'd7));
    send_item(make_item(3'd6, 16'd0, 5'd24, 6'd0, 6'd0, 16'd0, 5'd24, 6'd0, 6'd0, 16'd0));
    send_item(make_item(3'd7, 16'hFFFF, 5'd31, 6'd63, 6'd63,
                        16'd0, 5'd0, 6'd0, 6'd0, 16'hFFFF));
    // compare decided by the lowest field, then by hours alone
    send_item(make_item(CMD_ADD, 16'd8, 5'd3, 6'd4, 6'd5, 16'd8, 5'd3, 6'd4, 6'd6, 16'd0));
    send_item(make_item(CMD_ADD, 16'd8, 5'd9, 6'd0, 6'd0, 16'd8, 5'd3, 6'd59, 6'd59, 16'd0));
  endtask

  task automatic test_random_items(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_item(rand_duration_item());
  endtask

  // The receiver stops for a long stretch while items keep coming: the pipe
  // fills, op_stall must rise, and nothing may be lost or duplicated.
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_res <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_res <= 1'b0;
      end
    join_none
    repeat (40) send_item(rand_duration_item());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 47;
    test_directed_cases();
    test_random_items(330, 23, 47);
    test_random_items(330, 47, 23);
    test_random_items(330, 0, 0);
    test_output_hold_off();

    // drain: all results back, then a few more cycles for anything stray
    op_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
